FILE: design/grrqs_pkg.sv
// Package for the grouped round-robin queue scheduler.
// Holds defaults, operation codes, the controller state type and the
// command/status structs. No dependencies.
`default_nettype none
package grrqs_pkg;

  localparam int NUM_QUEUES_DEF   = 8;
  localparam int NUM_GROUPS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int ELEMENT_BITS_DEF = 16;

  localparam int ELEM_W  = 16;
  localparam int QID_W   = 3;
  localparam int MAP_W   = 24;
  localparam int GFLD_W  = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_GET    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDR,
    ST_POP2,
    ST_RDQ,
    ST_SRD,
    ST_SCK,
    ST_SHC,
    ST_MRD,
    ST_MWR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // latch request, target := queue_id
    logic q_push;     // write element at tail of target queue
    logic q_pop;      // read head of target queue, advance
    logic r_append;   // append target to its group's ready list
    logic r_pop;      // read head of ready list, advance
    logic t_from_r;   // target := ready list read data
    logic r_rd_idx;   // read ready list at scan index
    logic r_rd_next;  // read ready list at scan index + 1
    logic r_wr_idx;   // write last read entry at scan index
    logic r_dec;      // ready count minus one
    logic idx_clr;
    logic idx_inc;
    logic res_drop;
    logic res_woke;
    logic res_got;
    logic res_elem;
  } cmd_t;

  typedef struct packed {
    logic q_ok;       // queue id in range
    logic op_get;
    logic g_zero;     // request's group is not combined
    logic q_full;
    logic q_empty;
    logic q_last;     // target queue holds exactly one element
    logic r_empty;
    logic r_full;
    logic idx_last;   // scan index is the last list position
    logic match;      // ready read data equals target queue
  } sts_t;

endpackage
`default_nettype wire

FILE: design/grrqs_dp.sv
// Datapath: queue storage, ready-list storage, pointers, counts and result
// registers. Depends on grrqs_pkg; driven by grrqs_ctrl commands.
`default_nettype none
module grrqs_dp #(
  parameter int NUM_QUEUES   = grrqs_pkg::NUM_QUEUES_DEF,
  parameter int NUM_GROUPS   = grrqs_pkg::NUM_GROUPS_DEF,
  parameter int QUEUE_DEPTH  = grrqs_pkg::QUEUE_DEPTH_DEF,
  parameter int ELEMENT_BITS = grrqs_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [grrqs_pkg::MAP_W-1:0] cfg_wdata,
  input  wire logic                        in_operation,
  input  wire logic [grrqs_pkg::QID_W-1:0] in_queue_id,
  input  wire logic [grrqs_pkg::ELEM_W-1:0] in_element,
  input  wire grrqs_pkg::cmd_t             cmd,
  output grrqs_pkg::sts_t                  sts,
  output logic [grrqs_pkg::ELEM_W-1:0]     out_element_out,
  output logic                             out_got_element,
  output logic [grrqs_pkg::QID_W-1:0]      out_from_queue,
  output logic                             out_group_woke,
  output logic                             out_dropped_full
);

  localparam int QW  = $clog2(NUM_QUEUES);
  localparam int QCW = $clog2(NUM_QUEUES + 1);
  localparam int GW  = $clog2(NUM_GROUPS);
  localparam int DW  = $clog2(QUEUE_DEPTH);
  localparam int DCW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW  = (ELEMENT_BITS < grrqs_pkg::ELEM_W) ? ELEMENT_BITS : grrqs_pkg::ELEM_W;
  localparam int QM_DEPTH = NUM_QUEUES * (2 ** DW);
  localparam int RM_DEPTH = NUM_GROUPS * (2 ** QW);

  logic [grrqs_pkg::MAP_W-1:0] map_r;
  logic                        op_r;
  logic                        qok_r;
  logic [QW-1:0]               t_r;
  logic [GW-1:0]               g_r;
  logic [EW-1:0]               elem_r;
  logic [QCW-1:0]              idx_r;

  logic [DW-1:0]  qhead_r  [NUM_QUEUES];
  logic [DCW-1:0] qcount_r [NUM_QUEUES];
  logic [QW-1:0]  rhead_r  [NUM_GROUPS];
  logic [QCW-1:0] rcount_r [NUM_GROUPS];

  logic [EW-1:0] qmem [QM_DEPTH];
  logic [QW-1:0] rmem [RM_DEPTH];
  logic [EW-1:0] qdata_r;
  logic [QW-1:0] rdata_r;

  logic [EW-1:0] res_elem_r;
  logic          got_r, woke_r, drop_r;
  logic [grrqs_pkg::QID_W-1:0] from_r;

  function automatic logic [QW-1:0] rwrap(input logic [QW-1:0] b, input logic [QCW-1:0] o);
    logic [QCW:0] s;
    s = (QCW+1)'(b) + (QCW+1)'(o);
    if (s >= (QCW+1)'(NUM_QUEUES)) s = s - (QCW+1)'(NUM_QUEUES);
    return s[QW-1:0];
  endfunction

  function automatic logic [DW-1:0] qwrap(input logic [DW-1:0] b, input logic [DCW-1:0] o);
    logic [DCW:0] s;
    s = (DCW+1)'(b) + (DCW+1)'(o);
    if (s >= (DCW+1)'(QUEUE_DEPTH)) s = s - (DCW+1)'(QUEUE_DEPTH);
    return s[DW-1:0];
  endfunction

  // group lookup for the incoming request
  localparam int GFLD_LOC = grrqs_pkg::GFLD_W;
  logic [GFLD_LOC-1:0] g_raw;
  logic [GW-1:0] g_in;
  always_comb begin
    g_raw = map_r[GFLD_LOC*in_queue_id +: GFLD_LOC];
    g_in  = (32'(g_raw) < NUM_GROUPS) ? GW'(g_raw) : '0;
  end

  logic [DW-1:0]  qh;
  logic [DCW-1:0] qc;
  logic [QW-1:0]  rh;
  logic [QCW-1:0] rc;
  logic [QCW-1:0] idx_p1;
  assign qh     = qhead_r[t_r];
  assign qc     = qcount_r[t_r];
  assign rh     = rhead_r[g_r];
  assign rc     = rcount_r[g_r];
  assign idx_p1 = idx_r + QCW'(1);

  always_comb begin
    sts.q_ok     = qok_r;
    sts.op_get   = (op_r == grrqs_pkg::OP_GET);
    sts.g_zero   = (g_r == '0);
    sts.q_full   = (qc >= DCW'(QUEUE_DEPTH));
    sts.q_empty  = (qc == '0);
    sts.q_last   = (qc == DCW'(1));
    sts.r_empty  = (rc == '0);
    sts.r_full   = (rc >= QCW'(NUM_QUEUES));
    sts.idx_last = ((QCW+1)'(idx_r) + (QCW+1)'(1)) >= (QCW+1)'(rc);
    sts.match    = (rdata_r == t_r);
  end

  // request latch and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else if (cfg_we) begin
      map_r <= cfg_wdata;
    end
    if (cmd.load) begin
      op_r   <= in_operation;
      qok_r  <= (32'(in_queue_id) < NUM_QUEUES);
      t_r    <= QW'(in_queue_id);
      g_r    <= g_in;
      elem_r <= in_element[EW-1:0];
    end else if (cmd.t_from_r) begin
      t_r <= rdata_r;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_p1;
    end
  end

  // queue pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qhead_r[i]  <= '0;
        qcount_r[i] <= '0;
      end
    end else if (cmd.q_push) begin
      qcount_r[t_r] <= qc + DCW'(1);
    end else if (cmd.q_pop) begin
      qhead_r[t_r]  <= qwrap(qh, DCW'(1));
      qcount_r[t_r] <= qc - DCW'(1);
    end
  end

  // ready-list pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        rhead_r[i]  <= '0;
        rcount_r[i] <= '0;
      end
    end else if (cmd.r_append) begin
      rcount_r[g_r] <= rc + QCW'(1);
    end else if (cmd.r_pop) begin
      rhead_r[g_r]  <= rwrap(rh, QCW'(1));
      rcount_r[g_r] <= rc - QCW'(1);
    end else if (cmd.r_dec) begin
      rcount_r[g_r] <= rc - QCW'(1);
    end
  end

  // element store
  always_ff @(posedge clk) begin
    if (cmd.q_push) qmem[{t_r, qwrap(qh, qc)}] <= elem_r;
    if (cmd.q_pop)  qdata_r <= qmem[{t_r, qh}];
  end

  // ready-list store
  logic [QW-1:0] r_rd_slot;
  always_comb begin
    r_rd_slot = rh;
    if (cmd.r_rd_idx)  r_rd_slot = rwrap(rh, idx_r);
    if (cmd.r_rd_next) r_rd_slot = rwrap(rh, idx_p1);
  end

  always_ff @(posedge clk) begin
    if (cmd.r_append) rmem[{g_r, rwrap(rh, rc)}] <= t_r;
    if (cmd.r_wr_idx) rmem[{g_r, rwrap(rh, idx_r)}] <= rdata_r;
    if (cmd.r_pop || cmd.r_rd_idx || cmd.r_rd_next) rdata_r <= rmem[{g_r, r_rd_slot}];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_elem_r <= '0;
      got_r      <= 1'b0;
      from_r     <= '0;
      woke_r     <= 1'b0;
      drop_r     <= 1'b0;
    end else begin
      if (cmd.res_drop) drop_r <= 1'b1;
      if (cmd.res_woke) woke_r <= sts.r_empty;
      if (cmd.res_got) begin
        got_r  <= 1'b1;
        from_r <= grrqs_pkg::QID_W'(t_r);
      end
      if (cmd.res_elem) res_elem_r <= qdata_r;
    end
  end

  assign out_element_out  = grrqs_pkg::ELEM_W'(res_elem_r);
  assign out_got_element  = got_r;
  assign out_from_queue   = from_r;
  assign out_group_woke   = woke_r;
  assign out_dropped_full = drop_r;

endmodule
`default_nettype wire

FILE: design/grrqs_ctrl.sv
// Controller state machine for the scheduler. Issues commands to
// grrqs_dp and sequences pops, rotation and group-0 compaction. Uses grrqs_pkg.
`default_nettype none
module grrqs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire grrqs_pkg::sts_t  sts,
  output grrqs_pkg::cmd_t       cmd,
  output logic                  busy,
  output logic                  out_valid
);

  grrqs_pkg::state_t state_r, state_nxt;
  logic cmp_r, cmp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grrqs_pkg::ST_IDLE;
      cmp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      grrqs_pkg::ST_IDLE: if (start) state_nxt = grrqs_pkg::ST_EXEC;
      grrqs_pkg::ST_EXEC: begin
        state_nxt = grrqs_pkg::ST_OUT;
        if (sts.q_ok && sts.op_get) begin
          if (sts.g_zero) begin
            if (!sts.q_empty) state_nxt = grrqs_pkg::ST_RDQ;
          end else if (!sts.r_empty) begin
            state_nxt = grrqs_pkg::ST_RDR;
          end
        end
      end
      grrqs_pkg::ST_RDR:  state_nxt = grrqs_pkg::ST_POP2;
      grrqs_pkg::ST_POP2: state_nxt = sts.q_empty ? grrqs_pkg::ST_OUT : grrqs_pkg::ST_RDQ;
      grrqs_pkg::ST_RDQ:
        state_nxt = (cmp_r && !sts.r_empty) ? grrqs_pkg::ST_SRD : grrqs_pkg::ST_OUT;
      grrqs_pkg::ST_SRD:  state_nxt = grrqs_pkg::ST_SCK;
      grrqs_pkg::ST_SCK: begin
        if (sts.match)         state_nxt = grrqs_pkg::ST_SHC;
        else if (sts.idx_last) state_nxt = grrqs_pkg::ST_OUT;
        else                   state_nxt = grrqs_pkg::ST_SRD;
      end
      grrqs_pkg::ST_SHC:  state_nxt = sts.idx_last ? grrqs_pkg::ST_OUT : grrqs_pkg::ST_MRD;
      grrqs_pkg::ST_MRD:  state_nxt = grrqs_pkg::ST_MWR;
      grrqs_pkg::ST_MWR:  state_nxt = grrqs_pkg::ST_SHC;
      grrqs_pkg::ST_OUT:  state_nxt = grrqs_pkg::ST_IDLE;
      default:            state_nxt = grrqs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmp_nxt   = cmp_r;
    busy      = (state_r != grrqs_pkg::ST_IDLE);
    out_valid = (state_r == grrqs_pkg::ST_OUT);
    case (state_r)
      grrqs_pkg::ST_IDLE: begin
        cmp_nxt  = 1'b0;
        cmd.load = start;
      end
      grrqs_pkg::ST_EXEC: begin
        if (sts.q_ok) begin
          if (!sts.op_get) begin
            if (sts.q_full) begin
              cmd.res_drop = 1'b1;
            end else begin
              cmd.q_push = 1'b1;
              if (sts.q_empty) begin
                cmd.res_woke = 1'b1;
                cmd.r_append = !sts.r_full;
              end
            end
          end else if (sts.g_zero) begin
            if (!sts.q_empty) begin
              cmd.q_pop   = 1'b1;
              cmd.res_got = 1'b1;
              cmp_nxt     = sts.q_last;
            end
          end else begin
            cmd.r_pop = !sts.r_empty;
          end
        end
      end
      grrqs_pkg::ST_RDR: cmd.t_from_r = 1'b1;
      grrqs_pkg::ST_POP2: begin
        if (!sts.q_empty) begin
          cmd.q_pop    = 1'b1;
          cmd.res_got  = 1'b1;
          cmd.r_append = !sts.q_last && !sts.r_full;
        end
      end
      grrqs_pkg::ST_RDQ: begin
        cmd.res_elem = 1'b1;
        cmd.idx_clr  = 1'b1;
      end
      grrqs_pkg::ST_SRD: cmd.r_rd_idx = 1'b1;
      grrqs_pkg::ST_SCK: cmd.idx_inc = !sts.match && !sts.idx_last;
      grrqs_pkg::ST_SHC: cmd.r_dec = sts.idx_last;
      grrqs_pkg::ST_MRD: cmd.r_rd_next = 1'b1;
      grrqs_pkg::ST_MWR: begin
        cmd.r_wr_idx = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      grrqs_pkg::ST_OUT: cmd = '0;
      default:           cmd = '0;
    endcase
  end

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("result strobe not followed by idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_cmp_group0: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_r && busy) |-> sts.g_zero) else $error("compaction outside group 0");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.r_append |-> !sts.r_full) else $error("append to full ready list");

endmodule
`default_nettype wire

FILE: design/grouped_round_robin_queue_scheduler.sv
// Grouped round-robin queue scheduler: per-queue FIFOs with per-group ready lists.
// Insert, or get on empty queue/group: EXEC, OUT. Group-0 get: EXEC, RDQ, OUT. Combined
// group: EXEC, RDR, POP2, RDQ, OUT (no RDQ on a stale ready head). Group-0 compaction:
// SRD, SCK per scanned ready entry; SHC, MRD, MWR per shifted entry; SHC to close. One
// request at a time, next accepted the cycle after the strobe; receiver cannot stall.
// Reset (rst_n low, synchronous) empties all queues and ready lists and clears the map.
`default_nettype none
module grouped_round_robin_queue_scheduler #(
  parameter int NUM_QUEUES   = grrqs_pkg::NUM_QUEUES_DEF,
  parameter int NUM_GROUPS   = grrqs_pkg::NUM_GROUPS_DEF,
  parameter int QUEUE_DEPTH  = grrqs_pkg::QUEUE_DEPTH_DEF,
  parameter int ELEMENT_BITS = grrqs_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration: group map, three bits per queue
  input  wire logic                         cfg_we,
  input  wire logic [grrqs_pkg::MAP_W-1:0]  cfg_wdata,
  // request transfer: accepted when start && !busy
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_operation,
  input  wire logic [grrqs_pkg::QID_W-1:0]  in_queue_id,
  input  wire logic [grrqs_pkg::ELEM_W-1:0] in_element,
  // result transfer: one-cycle strobe, cannot be held off
  output logic                              out_valid,
  output logic [grrqs_pkg::ELEM_W-1:0]      out_element_out,
  output logic                              out_got_element,
  output logic [grrqs_pkg::QID_W-1:0]       out_from_queue,
  output logic                              out_group_woke,
  output logic                              out_dropped_full
);

  grrqs_pkg::cmd_t cmd;
  grrqs_pkg::sts_t sts;

  // sequencing: pop/rotate of combined groups and group-0 compaction
  grrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // storage, pointers and result registers
  grrqs_dp #(
    .NUM_QUEUES   (NUM_QUEUES),
    .NUM_GROUPS   (NUM_GROUPS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_queue_id      (in_queue_id),
    .in_element       (in_element),
    .cmd              (cmd),
    .sts              (sts),
    .out_element_out  (out_element_out),
    .out_got_element  (out_got_element),
    .out_from_queue   (out_from_queue),
    .out_group_woke   (out_group_woke),
    .out_dropped_full (out_dropped_full)
  );

endmodule
`default_nettype wire
